FILE: rtl/core/dbfw_pkg.sv
package dbfw_pkg;

  localparam int DEF_GRID_WIDTH  = 17;
  localparam int DEF_GRID_HEIGHT = 9;

  localparam int BYTE_W  = 8;
  localparam int ROW_W   = 4;
  localparam int COL_W   = 5;
  localparam int VAL_W   = 5;
  localparam int GLYPH_W = 7;

  localparam logic [VAL_W-1:0] SAT_COUNT  = VAL_W'(14);
  localparam logic [VAL_W-1:0] START_MARK = VAL_W'(15);
  localparam logic [VAL_W-1:0] END_MARK   = VAL_W'(16);

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_BYTE   = 2'd1,
    OP_FINISH = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic       cap;      // latch input transaction
    logic       clear;    // clear grid, bishop to centre
    logic       move;     // one diagonal step, issue grid read
    logic [1:0] step;     // which bit pair of the byte
    logic       mark;     // write end mark at bishop
    logic       rd_issue; // issue grid read at read address
    logic       rd_take;  // capture read result
    logic       load;     // load output register
  } dbfw_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t op;
  } dbfw_sts_t;

  function automatic logic [GLYPH_W-1:0] glyph_of(logic [VAL_W-1:0] v);
    logic [GLYPH_W-1:0] g;
    unique case (v)
      5'd0:    g = 7'h20; // space
      5'd1:    g = 7'h2e; // .
      5'd2:    g = 7'h6f; // o
      5'd3:    g = 7'h2b; // +
      5'd4:    g = 7'h3d; // =
      5'd5:    g = 7'h2a; // *
      5'd6:    g = 7'h42; // B
      5'd7:    g = 7'h4f; // O
      5'd8:    g = 7'h58; // X
      5'd9:    g = 7'h40; // @
      5'd10:   g = 7'h25; // %
      5'd11:   g = 7'h26; // &
      5'd12:   g = 7'h23; // #
      5'd13:   g = 7'h2f; // /
      5'd14:   g = 7'h5e; // ^
      5'd15:   g = 7'h53; // S
      default: g = 7'h45; // E
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/core/dbfw_ctrl.sv
module dbfw_ctrl
  import dbfw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dbfw_sts_t sts,
  output dbfw_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_MOVE  = 7'b0000100,
    S_MARK  = 7'b0001000,
    S_RDADR = 7'b0010000,
    S_RDVAL = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.step  = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = 2'd0;
        if (accept) begin
          cmd.cap   = 1'b1;
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: begin
        // dispatch on the latched op
        unique case (sts.op)
          OP_START: begin
            cmd.clear = 1'b1;
            state_nxt = S_DONE;
          end
          OP_BYTE:   state_nxt = S_MOVE;
          OP_FINISH: state_nxt = S_MARK;
          default:   state_nxt = S_RDADR;
        endcase
      end
      S_MOVE: begin
        cmd.move = 1'b1;
        cnt_nxt  = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = S_DONE;
        end
      end
      S_MARK: begin
        cmd.mark  = 1'b1;
        state_nxt = S_DONE;
      end
      S_RDADR: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RDVAL;
      end
      S_RDVAL: begin
        cmd.rd_take = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/dbfw_dpath.sv
module dbfw_dpath
  import dbfw_pkg::*;
#(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dbfw_cmd_t          cmd,
  output dbfw_sts_t          sts,
  input  logic [1:0]         in_op,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic [ROW_W-1:0]   in_read_row,
  input  logic [COL_W-1:0]   in_read_col,
  output logic [VAL_W-1:0]   out_cell_value,
  output logic [GLYPH_W-1:0] out_glyph,
  output logic [COL_W-1:0]   out_bishop_col,
  output logic [ROW_W-1:0]   out_bishop_row
);

  localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [COL_W-1:0]  COL_MAX     = COL_W'(GRID_WIDTH - 1);
  localparam logic [ROW_W-1:0]  ROW_MAX     = ROW_W'(GRID_HEIGHT - 1);
  localparam logic [COL_W-1:0]  COL_CTR     = COL_W'(GRID_WIDTH / 2);
  localparam logic [ROW_W-1:0]  ROW_CTR     = ROW_W'(GRID_HEIGHT / 2);
  localparam logic [ADDR_W-1:0] CENTRE_ADDR =
    ADDR_W'((GRID_HEIGHT / 2) * GRID_WIDTH + GRID_WIDTH / 2);

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r,
                                                  logic [COL_W-1:0] c);
    return ADDR_W'(32'(r) * GRID_WIDTH + 32'(c));
  endfunction

  // latched transaction
  op_t               op_r;
  logic [BYTE_W-1:0] byte_r;
  logic [ROW_W-1:0]  rrow_r;
  logic [COL_W-1:0]  rcol_r;

  // bishop position
  logic [COL_W-1:0] pos_col_r, pos_col_nxt, step_col;
  logic [ROW_W-1:0] pos_row_r, pos_row_nxt, step_row;

  // grid storage, valid bits mark entries written since clear
  logic [VAL_W-1:0] mem [CELLS];
  logic [CELLS-1:0] vld_r;

  // read stage
  logic [ADDR_W-1:0] rd_addr, rd_addr_r;
  logic [VAL_W-1:0]  mem_q_r;
  logic              vld_q_r;
  logic              inc_pend_r;

  // write port and forwarding of the previous write
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, wr_addr_r;
  logic [VAL_W-1:0]  wr_data, wr_data_r;
  logic              fwd_vld_r;

  logic [VAL_W-1:0] cur_val, rd_val, res_val_r;
  logic [ROW_W-1:0] rd_row_cl;
  logic [COL_W-1:0] rd_col_cl;
  logic             go_right, go_down;

  logic [VAL_W-1:0]   out_val_r;
  logic [GLYPH_W-1:0] out_glyph_r;
  logic [COL_W-1:0]   out_col_r;
  logic [ROW_W-1:0]   out_row_r;

  assign sts.op = op_r;

  // one diagonal step with wall clamping per axis
  assign go_right = byte_r[{cmd.step, 1'b0}];
  assign go_down  = byte_r[{cmd.step, 1'b1}];

  always_comb begin
    if (go_right) begin
      step_col = (pos_col_r == COL_MAX) ? pos_col_r : pos_col_r + COL_W'(1);
    end else begin
      step_col = (pos_col_r == '0) ? pos_col_r : pos_col_r - COL_W'(1);
    end
    if (go_down) begin
      step_row = (pos_row_r == ROW_MAX) ? pos_row_r : pos_row_r + ROW_W'(1);
    end else begin
      step_row = (pos_row_r == '0) ? pos_row_r : pos_row_r - ROW_W'(1);
    end
  end

  always_comb begin
    priority if (cmd.clear) begin
      pos_col_nxt = COL_CTR;
      pos_row_nxt = ROW_CTR;
    end else if (cmd.move) begin
      pos_col_nxt = step_col;
      pos_row_nxt = step_row;
    end else begin
      pos_col_nxt = pos_col_r;
      pos_row_nxt = pos_row_r;
    end
  end

  assign rd_row_cl = (rrow_r > ROW_MAX) ? ROW_MAX : rrow_r;
  assign rd_col_cl = (rcol_r > COL_MAX) ? COL_MAX : rcol_r;
  assign rd_addr   = cmd.move ? cell_addr(step_row, step_col)
                              : cell_addr(rd_row_cl, rd_col_cl);

  // value at the read address: bypass the write of the previous cycle
  always_comb begin
    priority if (fwd_vld_r && (wr_addr_r == rd_addr_r)) begin
      cur_val = wr_data_r;
    end else if (vld_q_r) begin
      cur_val = mem_q_r;
    end else if (rd_addr_r == CENTRE_ADDR) begin
      cur_val = START_MARK;
    end else begin
      cur_val = '0;
    end
  end

  assign rd_val = (cur_val > END_MARK) ? END_MARK : cur_val;

  always_comb begin
    priority if (inc_pend_r) begin
      wr_en   = 1'b1;
      wr_addr = rd_addr_r;
      wr_data = (cur_val < SAT_COUNT) ? cur_val + VAL_W'(1) : cur_val;
    end else if (cmd.mark) begin
      wr_en   = 1'b1;
      wr_addr = cell_addr(pos_row_r, pos_col_r);
      wr_data = END_MARK;
    end else begin
      wr_en   = 1'b0;
      wr_addr = rd_addr_r;
      wr_data = cur_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.move || cmd.rd_issue) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_col_r  <= COL_CTR;
      pos_row_r  <= ROW_CTR;
      vld_r      <= '0;
      inc_pend_r <= 1'b0;
      fwd_vld_r  <= 1'b0;
      op_r       <= OP_START;
    end else begin
      pos_col_r  <= pos_col_nxt;
      pos_row_r  <= pos_row_nxt;
      inc_pend_r <= cmd.move;
      fwd_vld_r  <= wr_en;
      if (cmd.clear) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.cap) begin
        op_r <= op_t'(in_op);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr;
    vld_q_r   <= vld_r[rd_addr];
    wr_addr_r <= wr_addr;
    wr_data_r <= wr_data;
    if (cmd.cap) begin
      byte_r    <= in_data_byte;
      rrow_r    <= in_read_row;
      rcol_r    <= in_read_col;
      res_val_r <= '0;
    end else if (cmd.rd_take) begin
      res_val_r <= rd_val;
    end
    if (cmd.load) begin
      out_val_r   <= res_val_r;
      out_glyph_r <= glyph_of(res_val_r);
      out_col_r   <= pos_col_r;
      out_row_r   <= pos_row_r;
    end
  end

  assign out_cell_value = out_val_r;
  assign out_glyph      = out_glyph_r;
  assign out_bishop_col = out_col_r;
  assign out_bishop_row = out_row_r;

endmodule

FILE: rtl/core/drunken_bishop_fingerprint_walk.sv
// states from input transaction to out_valid: start clear, done; finish clear,
// mark, done; read clear, read address, read value, done; byte clear, four moves
// (one per cycle through a pipelined grid read-modify-write), done
// one transaction at a time, next accepted the cycle after the result is loaded
// reset: synchronous rst_n clears grid valid bits at once, bishop to the centre,
// no clearing pass; the centre reads as the start mark until written
module drunken_bishop_fingerprint_walk
  import dbfw_pkg::*;
#(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic [ROW_W-1:0]   in_read_row,
  input  logic [COL_W-1:0]   in_read_col,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VAL_W-1:0]   out_cell_value,
  output logic [GLYPH_W-1:0] out_glyph,
  output logic [COL_W-1:0]   out_bishop_col,
  output logic [ROW_W-1:0]   out_bishop_row
);

  // command and status between the sequencer and the grid datapath
  dbfw_cmd_t cmd;
  dbfw_sts_t sts;

  // sequencer: latches a transaction, runs the op, then waits for a free
  // output register before loading the result
  dbfw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: bishop position, grid RAM with valid bits, forwarding of the
  // previous write so back to back moves on the same cell count correctly
  dbfw_dpath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_data_byte   (in_data_byte),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_cell_value (out_cell_value),
    .out_glyph      (out_glyph),
    .out_bishop_col (out_bishop_col),
    .out_bishop_row (out_bishop_row)
  );

endmodule

FILE: sim/drunken_bishop_fingerprint_walk_tb.sv
`timescale 1ns / 100ps

module drunken_bishop_fingerprint_walk_tb;
  import dbfw_pkg::*;

  localparam int GRID_W = DEF_GRID_WIDTH;
  localparam int GRID_H = DEF_GRID_HEIGHT;
  localparam int IDLE_PCT = 36;
  // window of transactions with no idling on either side
  localparam int CALM_LO = 300;
  localparam int CALM_HI = 450;
  localparam int RANDOM_ITEMS = 900;
  // drain after the last result, a wide margin over the longest (byte) transaction
  localparam int DRAIN_CYCLES = 40;

  // one input transaction
  typedef struct packed {
    op_t                op;
    logic [BYTE_W-1:0]  data;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
  } walk_item_t;

  // one result transaction
  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic [GLYPH_W-1:0] glyph;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
  } cell_report_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_op = 2'd0;
  logic [BYTE_W-1:0]  in_data_byte = '0;
  logic [ROW_W-1:0]   in_read_row = '0;
  logic [COL_W-1:0]   in_read_col = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [VAL_W-1:0]   out_cell_value;
  logic [GLYPH_W-1:0] out_glyph;
  logic [COL_W-1:0]   out_bishop_col;
  logic [ROW_W-1:0]   out_bishop_row;

  walk_item_t   pending_items[$];
  cell_report_t cells_due[$];

  // shadow copy of the visit grid and bishop position
  logic [VAL_W-1:0] visits [0:GRID_H-1][0:GRID_W-1];
  logic [COL_W-1:0] bishop_c;
  logic [ROW_W-1:0] bishop_r;
  string glyph_chars = " .o+=*BOX@%&#/^SE";

  int n_accepted = 0;
  int n_checked = 0;
  int n_mismatch = 0;
  int op_seen [4] = '{0, 0, 0, 0};

  wire calm_in  = (n_accepted >= CALM_LO) && (n_accepted < CALM_HI);
  wire calm_out = (n_checked >= CALM_LO) && (n_checked < CALM_HI);

  drunken_bishop_fingerprint_walk DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_data_byte   (in_data_byte),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_value (out_cell_value),
    .out_glyph      (out_glyph),
    .out_bishop_col (out_bishop_col),
    .out_bishop_row (out_bishop_row)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the handshake hangs
  initial begin
    #5_000_000;
    $display("drunken_bishop_fingerprint_walk_tb: errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    n_mismatch++;
    $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // start transaction: empty grid, start mark in the centre, bishop on it
  task automatic clear_walk();
    for (int r = 0; r < GRID_H; r++)
      for (int c = 0; c < GRID_W; c++)
        visits[r][c] = '0;
    bishop_c = COL_W'(GRID_W / 2);
    bishop_r = ROW_W'(GRID_H / 2);
    visits[bishop_r][bishop_c] = START_MARK;
  endtask

  // four diagonal steps, low bit pair first; walls clamp each axis on its own
  task automatic walk_byte(input logic [BYTE_W-1:0] b);
    for (int k = 0; k < 4; k++) begin
      if (b[2*k])
        bishop_c = (bishop_c == COL_W'(GRID_W - 1)) ? bishop_c : bishop_c + COL_W'(1);
      else
        bishop_c = (bishop_c == '0) ? bishop_c : bishop_c - COL_W'(1);
      if (b[2*k+1])
        bishop_r = (bishop_r == ROW_W'(GRID_H - 1)) ? bishop_r : bishop_r + ROW_W'(1);
      else
        bishop_r = (bishop_r == '0) ? bishop_r : bishop_r - ROW_W'(1);
      // counts stop at saturation, start and end marks sit above it
      if (visits[bishop_r][bishop_c] < SAT_COUNT)
        visits[bishop_r][bishop_c] = visits[bishop_r][bishop_c] + VAL_W'(1);
    end
  endtask

  // apply one accepted transaction to the shadow state and queue its result
  task automatic predict_cell(input walk_item_t it);
    cell_report_t res;
    logic [ROW_W-1:0] rr;
    logic [COL_W-1:0] cc;
    res.value = '0;
    case (it.op)
      OP_START:  clear_walk();
      OP_BYTE:   walk_byte(it.data);
      OP_FINISH: visits[bishop_r][bishop_c] = END_MARK;
      OP_READ: begin
        // out-of-range read addresses land on the last row or column
        rr = (it.row > ROW_W'(GRID_H - 1)) ? ROW_W'(GRID_H - 1) : it.row;
        cc = (it.col > COL_W'(GRID_W - 1)) ? COL_W'(GRID_W - 1) : it.col;
        res.value = visits[rr][cc];
      end
      default: ;
    endcase
    // non-read transactions report a zero cell, whose glyph is a space
    res.glyph = GLYPH_W'(glyph_chars.getc(int'(res.value)));
    res.col   = bishop_c;
    res.row   = bishop_r;
    cells_due.push_back(res);
    op_seen[int'(it.op)]++;
  endtask

  task automatic queue_item(input op_t op, input int b, input int r, input int c);
    walk_item_t it;
    it.op   = op;
    it.data = BYTE_W'(b);
    it.row  = ROW_W'(r);
    it.col  = COL_W'(c);
    pending_items.push_back(it);
  endtask

  // driver: take the transaction at the edge it is accepted, then maybe present the next
  always @(posedge clk) begin : drive_side
    walk_item_t nxt;
    walk_item_t cur;
    logic idle_now;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cur.op   = op_t'(in_op);
        cur.data = in_data_byte;
        cur.row  = in_read_row;
        cur.col  = in_read_col;
        predict_cell(cur);
        n_accepted++;
      end
      // a held transaction stays untouched until accepted
      if (!in_valid || in_ready) begin
        idle_now = !calm_in && ($urandom_range(0, 99) < IDLE_PCT);
        if (pending_items.size() != 0 && !idle_now) begin
          nxt = pending_items.pop_front();
          in_valid     <= 1'b1;
          in_op        <= nxt.op;
          in_data_byte <= nxt.data;
          in_read_row  <= nxt.row;
          in_read_col  <= nxt.col;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: every result must match the oldest one still due
  always @(posedge clk) begin : check_side
    cell_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (cells_due.size() == 0) begin
        report_mismatch("result with nothing due, cell_value", int'(out_cell_value), 0);
      end else begin
        want = cells_due.pop_front();
        n_checked++;
        if (out_cell_value !== want.value)
          report_mismatch("cell_value", int'(out_cell_value), int'(want.value));
        if (out_glyph !== want.glyph)
          report_mismatch("glyph", int'(out_glyph), int'(want.glyph));
        if (out_bishop_col !== want.col)
          report_mismatch("bishop_col", int'(out_bishop_col), int'(want.col));
        if (out_bishop_row !== want.row)
          report_mismatch("bishop_row", int'(out_bishop_row), int'(want.row));
      end
    end
    out_ready <= calm_out || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  initial begin : stimulus
    int n_bytes;
    int n_reads;
    int kind;
    clear_walk();

    // directed: reads after reset, incl. clamped address
    queue_item(OP_READ, 0, GRID_H / 2, GRID_W / 2);
    queue_item(OP_READ, 0, 15, 31);
    queue_item(OP_READ, 0, 0, 0);
    // up-left into the top-left corner, then sit there until the count saturates
    for (int i = 0; i < 7; i++)
      queue_item(OP_BYTE, 8'h00, 0, 0);
    queue_item(OP_READ, 0, 0, 0);
    queue_item(OP_READ, 0, 0, 1);
    // down-right across to the opposite corner, then mark the end
    for (int i = 0; i < 4; i++)
      queue_item(OP_BYTE, 8'hff, 0, 0);
    queue_item(OP_FINISH, 0, 0, 0);
    queue_item(OP_READ, 0, GRID_H - 1, GRID_W - 1);
    // keep walking after finish: slide along the right wall, back over the end mark
    queue_item(OP_BYTE, 8'h55, 0, 0);
    queue_item(OP_BYTE, 8'haa, 0, 0);
    queue_item(OP_BYTE, 8'h1b, 0, 0);
    queue_item(OP_BYTE, 8'hff, 0, 0);
    queue_item(OP_READ, 0, GRID_H - 1, GRID_W - 1);
    // restart wipes the end mark
    queue_item(OP_START, 0, 0, 0);
    queue_item(OP_READ, 0, GRID_H - 1, GRID_W - 1);
    queue_item(OP_READ, 0, GRID_H / 2, GRID_W / 2);

    // random: mostly whole fingerprints (start, bytes, finish, reads), some noise
    while (pending_items.size() < RANDOM_ITEMS + 26) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        // now and then continue the previous walk instead of restarting
        if ($urandom_range(0, 9) != 0)
          queue_item(OP_START, $urandom_range(0, 255), $urandom_range(0, 15),
                     $urandom_range(0, 31));
        // a few long walks push cells into saturation
        n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 48) : $urandom_range(1, 20);
        for (int i = 0; i < n_bytes; i++)
          queue_item(OP_BYTE, $urandom_range(0, 255), $urandom_range(0, 15),
                     $urandom_range(0, 31));
        if ($urandom_range(0, 9) < 7)
          queue_item(OP_FINISH, $urandom_range(0, 255), $urandom_range(0, 15),
                     $urandom_range(0, 31));
        n_reads = $urandom_range(2, 10);
        for (int i = 0; i < n_reads; i++) begin
          if ($urandom_range(0, 3) != 0)
            queue_item(OP_READ, $urandom_range(0, 255), $urandom_range(0, GRID_H - 1),
                       $urandom_range(0, GRID_W - 1));
          else
            queue_item(OP_READ, $urandom_range(0, 255), $urandom_range(0, 15),
                       $urandom_range(0, 31));
        end
      end else begin
        // noise: any op, every field over its full width
        n_reads = $urandom_range(1, 8);
        for (int i = 0; i < n_reads; i++)
          queue_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                     $urandom_range(0, 15), $urandom_range(0, 31));
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // wait for the queue to empty and every result to come back
    while (pending_items.size() != 0 || in_valid || cells_due.size() != 0)
      @(posedge clk);
    // catch any stray result after the last one
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("walked %0d transactions: %0d start, %0d byte, %0d finish, %0d read",
             n_accepted, op_seen[OP_START], op_seen[OP_BYTE], op_seen[OP_FINISH],
             op_seen[OP_READ]);
    $display("compared %0d results, %0d mismatches", n_checked, n_mismatch);
    if (n_mismatch == 0 && cells_due.size() == 0)
      $display("drunken_bishop_fingerprint_walk_tb: clean");
    else
      $display("drunken_bishop_fingerprint_walk_tb: errors");
    $finish;
  end

endmodule
